// ===== design/dccs_pkg.sv =====
// Shared types, constants and helpers of the duty-cycle channel scheduler.
// No dependencies.
`timescale 1ns / 1ps
package dccs_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int CH_W = 4;

    typedef enum logic [2:0] {
        ACT_INIT    = 3'd0,
        ACT_CONFIG  = 3'd1,
        ACT_DISABLE = 3'd2,
        ACT_MASK    = 3'd3,
        ACT_RECORD  = 3'd4,
        ACT_NEXT    = 3'd5
    } action_t;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    localparam logic [2:0] MASK_ALL = 3'd6;
    localparam logic [2:0] MASK_APPLY = 3'd0;

    localparam logic [30:0] MAX_WAIT_RESET = 31'd943718400;
    localparam logic [15:0] DEFAULT_RATES = 16'h003F;

    localparam logic [29:0] FREQ_DEF0 = 30'd868100000;
    localparam logic [29:0] FREQ_DEF1 = 30'd868300000;
    localparam logic [29:0] FREQ_DEF2 = 30'd868500000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RESET_BANDS,
        S_PICK,
        S_WALK,
        S_REC_MUL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  channel_index;
        logic [29:0] frequency;
        logic [15:0] rate_map;
        logic [2:0]  mask_control;
        logic [15:0] channel_mask;
        logic [31:0] time_now;
        logic [21:0] airtime;
        logic [3:0]  data_rate;
        logic [23:0] random_bits;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  channel;
        logic [1:0]  band;
        logic [29:0] tx_frequency;
        logic [31:0] ready_time;
    } rsp_t;

    function automatic logic [1:0] classify(input logic [29:0] f);
        logic [1:0] b;
        b = 2'd0;
        if (f >= 30'd869400000 && f <= 30'd869650000)
            b = 2'd2;
        else if ((f >= 30'd868000000 && f <= 30'd868600000)
                 || (f >= 30'd869700000 && f <= 30'd870000000))
            b = 2'd1;
        return b;
    endfunction

    function automatic logic [9:0] band_cap(input logic [1:0] b);
        logic [9:0] c;
        case (b)
            2'd0: c = 10'd1000;
            2'd1: c = 10'd100;
            default: c = 10'd10;
        endcase
        return c;
    endfunction

endpackage

// ===== design/dccs_chan_table.sv =====
// Channel table: frequency, band, rate map and enable per channel.
// Depends on dccs_pkg.
`timescale 1ns / 1ps
module dccs_chan_table (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [dccs_pkg::CH_W-1:0] wr_idx,
    input  logic [29:0]               wr_freq,
    input  logic [15:0]               wr_rates,
    input  logic                      en_load,
    input  logic [dccs_pkg::NUM_CHANNELS-1:0] en_next,
    input  logic [dccs_pkg::CH_W-1:0] rd_idx,
    output logic [29:0]               rd_freq,
    output logic [1:0]                rd_band,
    output logic [15:0]               rd_rates,
    output logic [dccs_pkg::NUM_CHANNELS-1:0] enabled
);
    import dccs_pkg::*;

    logic [29:0] freq_reg  [NUM_CHANNELS];
    logic [1:0]  band_reg  [NUM_CHANNELS];
    logic [15:0] rates_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                freq_reg[i]  <= '0;
                band_reg[i]  <= '0;
                rates_reg[i] <= '0;
            end
            en_reg <= '0;
        end
        else
        begin
            if (en_load)
                en_reg <= en_next;
            if (wr_en)
            begin
                freq_reg[wr_idx]  <= wr_freq;
                band_reg[wr_idx]  <= classify(wr_freq);
                rates_reg[wr_idx] <= (wr_rates == '0) ? DEFAULT_RATES : wr_rates;
            end
        end
    end

    assign rd_freq  = freq_reg[rd_idx];
    assign rd_band  = band_reg[rd_idx];
    assign rd_rates = rates_reg[rd_idx];
    assign enabled  = en_reg;
endmodule

// ===== design/duty_cycle_channel_scheduler_unit.sv =====
// Top level of the duty-cycle channel scheduler: sequencer, band registers
// and one shared 32-bit adder/comparator. Depends on dccs_pkg, dccs_chan_table.
`timescale 1ns / 1ps
// A command is taken when start is high and busy is low; its one result shows
// on rsp with done high for a single cycle and cannot be held off. Disable,
// configure, mask and rejected actions go straight to the result; init makes
// three table writes, the last one together with the band reset; record
// multiplies, then adds; next runs band compares and then a channel walk per
// round, over at most 4 rounds, one band compare through the shared unit or
// one channel probe per cycle.
module duty_cycle_channel_scheduler_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  dccs_pkg::cmd_t   cmd,
    output logic             done,
    output dccs_pkg::rsp_t   rsp,
    input  logic             max_wait_we,
    input  logic [30:0]      max_wait_wdata
);
    import dccs_pkg::*;

    localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic [30:0] max_wait_reg;
    logic [31:0] band_ready_reg [3];
    logic [31:0] band_ready_next [3];
    logic [CH_W-1:0] last_reg [3];
    logic [CH_W-1:0] last_next [3];
    logic [CH_W-1:0] tx_reg, tx_next;
    logic [1:0] status_reg, status_next;
    logic [29:0] txf_reg, txf_next;
    logic [31:0] ready_reg, ready_next;
    logic done_reg, done_next;
    logic [1:0] step_reg, step_next;
    logic [2:0] bmap_reg, bmap_next;
    logic [2:0] round_reg, round_next;
    logic [31:0] mint_reg, mint_next;
    logic [1:0] band_reg, band_next;
    logic found_band_reg, found_band_next;
    logic [CH_W-1:0] ch_reg, ch_next;
    logic [CNT_W-1:0] ci_reg, ci_next;
    logic [31:0] prod_reg, prod_next;

    logic wr_en, en_load;
    logic [CH_W-1:0] wr_idx, rd_idx;
    logic [29:0] wr_freq, rd_freq;
    logic [15:0] wr_rates, rd_rates;
    logic [1:0] rd_band;
    logic [NUM_CHANNELS-1:0] enabled, en_next;

    logic [31:0] alu_a, alu_b, alu_sum;
    logic alu_sub;

    dccs_chan_table u_table (
        .clk(clk), .rst_n(rst_n),
        .wr_en(wr_en), .wr_idx(wr_idx), .wr_freq(wr_freq), .wr_rates(wr_rates),
        .en_load(en_load), .en_next(en_next),
        .rd_idx(rd_idx), .rd_freq(rd_freq), .rd_band(rd_band),
        .rd_rates(rd_rates), .enabled(enabled)
    );

    // shared adder
    assign alu_sum = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    function automatic logic [CH_W-1:0] wrap_inc(input logic [CH_W-1:0] c);
        logic [CH_W:0] n;
        n = {1'b0, c} + 1'b1;
        if (n >= (CH_W+1)'(NUM_CHANNELS))
            n = n - (CH_W+1)'(NUM_CHANNELS);
        return n[CH_W-1:0];
    endfunction

    function automatic logic [CH_W-1:0] rnd_chan(input logic [7:0] r);
        return CH_W'(r % NUM_CHANNELS);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            max_wait_reg <= MAX_WAIT_RESET;
            for (int i = 0; i < 3; i++)
            begin
                band_ready_reg[i] <= '0;
                last_reg[i] <= '0;
            end
            tx_reg <= '0;
            done_reg <= 1'b0;
            step_reg <= '0;
            bmap_reg <= '0;
            round_reg <= '0;
            band_reg <= '0;
            found_band_reg <= 1'b0;
            ch_reg <= '0;
            ci_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (max_wait_we)
                max_wait_reg <= max_wait_wdata;
            for (int i = 0; i < 3; i++)
            begin
                band_ready_reg[i] <= band_ready_next[i];
                last_reg[i] <= last_next[i];
            end
            tx_reg <= tx_next;
            done_reg <= done_next;
            step_reg <= step_next;
            bmap_reg <= bmap_next;
            round_reg <= round_next;
            band_reg <= band_next;
            found_band_reg <= found_band_next;
            ch_reg <= ch_next;
            ci_reg <= ci_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        status_reg <= status_next;
        txf_reg <= txf_next;
        ready_reg <= ready_next;
        mint_reg <= mint_next;
        prod_reg <= prod_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        band_ready_next = band_ready_reg;
        last_next = last_reg;
        tx_next = tx_reg;
        status_next = status_reg;
        txf_next = txf_reg;
        ready_next = ready_reg;
        done_next = 1'b0;
        step_next = step_reg;
        bmap_next = bmap_reg;
        round_next = round_reg;
        mint_next = mint_reg;
        band_next = band_reg;
        found_band_next = found_band_reg;
        ch_next = ch_reg;
        ci_next = ci_reg;
        prod_next = prod_reg;
        wr_en = 1'b0;
        wr_idx = '0;
        wr_freq = '0;
        wr_rates = '0;
        en_load = 1'b0;
        en_next = enabled;
        rd_idx = tx_reg;
        alu_a = '0;
        alu_b = '0;
        alu_sub = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start && !busy)
                begin
                    cmd_next = cmd;
                    status_next = ST_OK;
                    txf_next = '0;
                    ready_next = '0;
                    step_next = '0;
                    state_next = S_DONE;
                    case (cmd.action)
                        ACT_INIT:
                        begin
                            en_load = 1'b1;
                            en_next = '0;
                            state_next = S_RESET_BANDS;
                        end
                        ACT_CONFIG:
                        begin
                            if (cmd.channel_index >= 8'(NUM_CHANNELS))
                                status_next = ST_REJECT;
                            else
                            begin
                                wr_en = 1'b1;
                                wr_idx = cmd.channel_index[CH_W-1:0];
                                wr_freq = cmd.frequency;
                                wr_rates = cmd.rate_map;
                                en_load = 1'b1;
                                en_next = enabled;
                                en_next[cmd.channel_index[CH_W-1:0]] = 1'b1;
                            end
                        end
                        ACT_DISABLE:
                        begin
                            if (cmd.channel_index >= 8'(NUM_CHANNELS))
                                status_next = ST_REJECT;
                            else
                            begin
                                en_load = 1'b1;
                                en_next = enabled;
                                en_next[cmd.channel_index[CH_W-1:0]] = 1'b0;
                            end
                        end
                        ACT_MASK:
                        begin
                            if (cmd.mask_control == MASK_ALL)
                            begin
                                en_load = 1'b1;
                                en_next = '1;
                            end
                            else if (cmd.mask_control != MASK_APPLY
                                     || cmd.channel_mask == '0)
                                status_next = ST_REJECT;
                            else
                            begin
                                en_load = 1'b1;
                                en_next = enabled
                                    | cmd.channel_mask[NUM_CHANNELS-1:0];
                            end
                        end
                        ACT_RECORD:
                        begin
                            state_next = S_REC_MUL;
                        end
                        ACT_NEXT:
                        begin
                            bmap_next = 3'b111;
                            round_next = '0;
                            step_next = '0;
                            mint_next = cmd.time_now + {1'b0, max_wait_reg};
                            found_band_next = 1'b0;
                            band_next = '0;
                            state_next = S_PICK;
                        end
                        default:
                            status_next = ST_REJECT;
                    endcase
                end
            end

            S_RESET_BANDS:
            begin
                // init: write default channel per step; the last step also sets the bands
                wr_en = 1'b1;
                wr_idx = CH_W'(step_reg);
                wr_rates = '0;
                case (step_reg)
                    2'd0: wr_freq = FREQ_DEF0;
                    2'd1: wr_freq = FREQ_DEF1;
                    default: wr_freq = FREQ_DEF2;
                endcase
                en_load = 1'b1;
                en_next = enabled;
                en_next[CH_W'(step_reg)] = 1'b1;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        band_ready_next[i] = cmd_reg.time_now;
                        last_next[i] = rnd_chan(cmd_reg.random_bits[8*i +: 8]);
                    end
                    state_next = S_DONE;
                end
            end

            S_REC_MUL:
            begin
                rd_idx = tx_reg;
                if (step_reg == 2'd0)
                begin
                    prod_next = 32'(band_cap(rd_band > 2'd2 ? 2'd2 : rd_band)
                                    * cmd_reg.airtime);
                    step_next = 2'd1;
                end
                else
                begin
                    alu_a = cmd_reg.time_now;
                    alu_b = prod_reg;
                    txf_next = rd_freq;
                    ready_next = alu_sum;
                    band_ready_next[(rd_band > 2'd2) ? 2'd2 : rd_band] = alu_sum;
                    state_next = S_DONE;
                end
            end

            S_PICK:
            begin
                // one band compare per step
                if (step_reg == 2'd3)
                begin
                    if (!found_band_reg)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            band_ready_next[i] = cmd_reg.time_now;
                            last_next[i] =
                                rnd_chan(cmd_reg.random_bits[8*i +: 8]);
                        end
                        band_next = '0;
                        ch_next = rnd_chan(cmd_reg.random_bits[7:0]);
                    end
                    else
                        ch_next = last_reg[band_reg];
                    ci_next = '0;
                    state_next = S_WALK;
                end
                else
                begin
                    alu_a = mint_reg;
                    alu_b = band_ready_reg[step_reg];
                    alu_sub = 1'b1;
                    if (bmap_reg[step_reg] && !alu_sum[31] && alu_sum != '0)
                    begin
                        band_next = step_reg;
                        found_band_next = 1'b1;
                        mint_next = band_ready_reg[step_reg];
                    end
                    step_next = step_reg + 2'd1;
                end
            end

            S_WALK:
            begin
                rd_idx = wrap_inc(ch_reg);
                if (ci_reg == CNT_W'(NUM_CHANNELS))
                begin
                    bmap_next = bmap_reg & ~(3'b001 << band_reg);
                    round_next = round_reg + 3'd1;
                    if (round_reg == 3'd3 || bmap_next == '0)
                    begin
                        status_next = ST_NONE;
                        ready_next = cmd_reg.time_now;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        step_next = '0;
                        found_band_next = 1'b0;
                        mint_next = cmd_reg.time_now + {1'b0, max_wait_reg};
                        state_next = S_PICK;
                    end
                end
                else
                begin
                    ch_next = rd_idx;
                    ci_next = ci_reg + 1'b1;
                    if (enabled[rd_idx] && rd_band == band_reg
                        && rd_rates[cmd_reg.data_rate])
                    begin
                        last_next[band_reg] = rd_idx;
                        tx_next = rd_idx;
                        ready_next = band_ready_reg[band_reg];
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                rd_idx = tx_reg;
                done_next = 1'b1;
                state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    logic [1:0] out_band;
    always_comb
    begin
        out_band = '0;
        if (state_reg == S_DONE)
            out_band = rd_band;
    end

    logic [1:0] band_hold_reg;
    always_ff @(posedge clk)
    begin
        band_hold_reg <= out_band;
    end

    assign busy = (state_reg != S_IDLE) || done_reg;
    assign done = done_reg;
    assign rsp.status = status_reg;
    assign rsp.channel = tx_reg;
    assign rsp.band = band_hold_reg;
    assign rsp.tx_frequency = txf_reg;
    assign rsp.ready_time = ready_reg;
endmodule
